// File: rtl/core/scld_pkg.sv
// Shared types and constants for the serial command line decoder.
package scld_pkg;

   // Input word: one received byte or a forced return to waiting mode
   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
      logic       buttons_accepted;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_char;
      logic       echo_valid;
      logic       echo_enabled;
      logic       dropped;
      logic       last;
   } rsp_word_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;     // take the input word and load its status result
      logic start;      // begin streaming the stored name
      logic emit_char;  // load the next name or suffix character
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_free;    // output register empty or being drained
      logic line_done;    // current input word completes a line
      logic stream_last;  // current stream character is the final one
   } ctl_status_type;

   // Input op codes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_FORCE = 1'b1;

   // Result kinds
   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_PREV   = 3'd1;
   localparam logic [2:0] KIND_PAUSE  = 3'd2;
   localparam logic [2:0] KIND_NEXT   = 3'd3;
   localparam logic [2:0] KIND_LIST   = 3'd4;
   localparam logic [2:0] KIND_DONE   = 3'd5;
   localparam logic [2:0] KIND_FINISH = 3'd6;
   localparam logic [2:0] KIND_CHAR   = 3'd7;

   // Parse modes; code 3 behaves as waiting
   localparam logic [1:0] MODE_WAIT = 2'd0;
   localparam logic [1:0] MODE_LINE = 2'd1;
   localparam logic [1:0] MODE_PLAY = 2'd2;

   // Command bytes
   localparam logic [7:0] CH_START  = 8'h53;  // 'S'
   localparam logic [7:0] CH_LIST   = 8'h52;  // 'R'
   localparam logic [7:0] CH_ECHO   = 8'h4F;  // 'O'
   localparam logic [7:0] CH_PREV   = 8'h42;  // 'B'
   localparam logic [7:0] CH_PAUSE  = 8'h50;  // 'P'
   localparam logic [7:0] CH_NEXT   = 8'h4E;  // 'N'
   localparam logic [7:0] CH_ABORT  = 8'h3C;  // '<'
   localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
   localparam logic [7:0] CH_FINISH = 8'h46;  // 'F'
   localparam logic [7:0] CH_BKSP   = 8'h08;
   localparam logic [7:0] CH_W      = 8'h57;  // 'W'
   localparam logic [7:0] CH_A      = 8'h41;  // 'A'
   localparam logic [7:0] CH_V      = 8'h56;  // 'V'

   // Characters of the ".WAV" suffix
   function automatic logic [7:0] suffix_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0: ch = CH_DOT;
         2'd1: ch = CH_W;
         2'd2: ch = CH_A;
         2'd3: ch = CH_V;
         default: ch = CH_DOT;
      endcase
      return ch;
   endfunction

endpackage

// File: rtl/core/serial_command_line_decoder_top.sv
// Top level of the serial command line decoder.
// Each accepted byte yields one status word; a byte that completes a name line then
// streams the stored name and ".WAV" as further words, one per cycle while the output
// is not stalled by rsp_ready, the final word flagged last. An input word is taken
// whenever the output register is free or being drained. A completed line holds off
// further input for its stream of name length + 4 characters, paced by the single
// output register and the one-read-per-cycle name memory.
// Characters beyond NAME_CHARS are not stored and are reported as dropped.
module serial_command_line_decoder_top #(
   parameter int NAME_CHARS = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scld_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output scld_pkg::rsp_word_type rsp_word
);
   import scld_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   scld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scld_datapath #(
      .NAME_CHARS (NAME_CHARS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// File: rtl/core/scld_ctrl.sv
// Controller state machine: input acceptance and name streaming sequence.
module scld_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  scld_pkg::ctl_status_type status,
   output scld_pkg::ctl_cmd_type    cmd
);
   import scld_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_STREAM = 1'b1;

   logic state_ff;
   logic state_in;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.start     = 1'b0;
      cmd.emit_char = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.slot_free;
            if (req_valid && status.slot_free) begin
               cmd.accept = 1'b1;
               if (status.line_done) begin
                  cmd.start = 1'b1;
                  state_in  = ST_STREAM;
               end
            end
         end
         ST_STREAM: begin
            if (status.slot_free) begin
               cmd.emit_char = 1'b1;
               if (status.stream_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/scld_datapath.sv
// Datapath: parse state, name memory, stream counter and output register.
module scld_datapath #(
   parameter int NAME_CHARS = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scld_pkg::req_word_type   req_word,
   input  scld_pkg::ctl_cmd_type    cmd,
   output scld_pkg::ctl_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output scld_pkg::rsp_word_type   rsp_word
);
   import scld_pkg::*;

   localparam int LEN_W = $clog2(NAME_CHARS + 1);
   localparam int IDX_W = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
   localparam int POS_W = $clog2(NAME_CHARS + 4);

   logic [1:0]       mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             echo_ff, echo_in;
   logic [LEN_W-1:0] stream_len_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       name_mem_ff [NAME_CHARS];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic [2:0]       kind;
   logic             drop;
   logic             done;
   logic [POS_W-1:0] stream_len_ext;
   logic [POS_W-1:0] suffix_off;
   logic [7:0]       stream_char;

   // Decode of the input word against the current mode
   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      echo_in = echo_ff;
      kind    = KIND_NONE;
      drop    = 1'b0;
      done    = 1'b0;
      wr_en   = 1'b0;
      if (req_word.op == OP_FORCE) begin
         mode_in = MODE_WAIT;
      end else begin
         case (mode_ff)
            MODE_LINE: begin
               if (req_word.rx_byte == CH_BKSP) begin
                  if (len_ff != '0) len_in = len_ff - LEN_W'(1);
               end else if (req_word.rx_byte == CH_ABORT) begin
                  mode_in = MODE_WAIT;
               end else if (req_word.rx_byte != CH_DOT) begin
                  if (len_ff < LEN_W'(NAME_CHARS)) begin
                     wr_en  = 1'b1;
                     len_in = len_ff + LEN_W'(1);
                  end else begin
                     drop = 1'b1;
                  end
               end else begin
                  kind    = KIND_DONE;
                  done    = 1'b1;
                  mode_in = MODE_PLAY;
                  len_in  = '0;
               end
            end
            MODE_PLAY: begin
               if (req_word.rx_byte == CH_FINISH) begin
                  kind    = KIND_FINISH;
                  mode_in = MODE_WAIT;
                  len_in  = '0;
               end
            end
            default: begin
               mode_in = MODE_WAIT;
               if (req_word.rx_byte == CH_START) begin
                  len_in  = '0;
                  mode_in = MODE_LINE;
               end else if (req_word.rx_byte == CH_LIST) begin
                  kind = KIND_LIST;
               end else if (req_word.rx_byte == CH_ECHO) begin
                  echo_in = ~echo_ff;
               end else if (req_word.buttons_accepted) begin
                  if (req_word.rx_byte == CH_PREV) kind = KIND_PREV;
                  else if (req_word.rx_byte == CH_PAUSE) kind = KIND_PAUSE;
                  else if (req_word.rx_byte == CH_NEXT) kind = KIND_NEXT;
               end
            end
         endcase
      end
   end

   // Stream position and character select
   assign stream_len_ext = POS_W'(stream_len_ff);
   assign suffix_off     = pos_ff - stream_len_ext;
   assign stream_char    = (pos_ff < stream_len_ext) ? rd_data_ff
                                                     : suffix_char(suffix_off[1:0]);

   always_comb begin
      pos_in = pos_ff;
      if (cmd.start) pos_in = '0;
      else if (cmd.emit_char) pos_in = pos_ff + POS_W'(1);
   end

   assign rd_addr = (pos_in < POS_W'(NAME_CHARS)) ? pos_in[IDX_W-1:0] : '0;

   // Output register load
   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (cmd.accept) begin
         rsp_word_in.kind         = kind;
         rsp_word_in.data_char    = (req_word.op == OP_FORCE) ? 8'd0 : req_word.rx_byte;
         rsp_word_in.echo_valid   = (req_word.op == OP_FORCE) ? 1'b0 : echo_in;
         rsp_word_in.echo_enabled = echo_in;
         rsp_word_in.dropped      = drop;
         rsp_word_in.last         = ~(done && (req_word.op == OP_BYTE));
      end else if (cmd.emit_char) begin
         rsp_word_in.kind         = KIND_CHAR;
         rsp_word_in.data_char    = stream_char;
         rsp_word_in.echo_valid   = 1'b0;
         rsp_word_in.echo_enabled = echo_ff;
         rsp_word_in.dropped      = 1'b0;
         rsp_word_in.last         = status.stream_last;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT;
         len_ff       <= '0;
         echo_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (cmd.accept) begin
            mode_ff <= mode_in;
            len_ff  <= len_in;
            echo_ff <= echo_in;
         end
         if (cmd.accept || cmd.emit_char) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (cmd.accept && done) stream_len_ff <= len_ff;
   end

   // Name memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en && (req_word.op == OP_BYTE)) begin
         name_mem_ff[len_ff[IDX_W-1:0]] <= req_word.rx_byte;
      end
      rd_data_ff <= name_mem_ff[rd_addr];
   end

   assign status.slot_free   = ~rsp_valid_ff | rsp_ready;
   assign status.line_done   = done && (req_word.op == OP_BYTE);
   assign status.stream_last = (pos_ff == stream_len_ext + POS_W'(3));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
